/* design/ntc_pkg.sv */
// Shared constants, tables and the divider stage record for the NTC reading converter.
// Used by every module in the design folder; depends on nothing else.
package ntc_pkg;

  localparam int TABLE_ENTRIES  = 15;
  localparam int ADC_FULL_SCALE = 4096;
  localparam int TOP_OHMS       = 100000;

  // Reading width for the valid range, numerator/quotient width and table index width.
  localparam int ADC_W = $clog2(ADC_FULL_SCALE);
  localparam int NUM_W = $clog2((ADC_FULL_SCALE - 1) * TOP_OHMS + 1);
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int TEMP_W = 8;

  localparam logic [NUM_W-1:0] OHMS [TABLE_ENTRIES] = '{
    NUM_W'(473000), NUM_W'(358200), NUM_W'(273400), NUM_W'(210200), NUM_W'(162900),
    NUM_W'(127200), NUM_W'(100000), NUM_W'(79210),  NUM_W'(63150),  NUM_W'(50670),
    NUM_W'(40900),  NUM_W'(33190),  NUM_W'(27090),  NUM_W'(22220),  NUM_W'(18320)
  };

  localparam logic signed [TEMP_W-1:0] CELSIUS [TABLE_ENTRIES] = '{
    -8'sd5, 8'sd0, 8'sd5, 8'sd10, 8'sd15, 8'sd20, 8'sd25, 8'sd30,
    8'sd35, 8'sd40, 8'sd45, 8'sd50, 8'sd55, 8'sd60, 8'sd65
  };

  // Sum of two neighbouring entries: twice the resistance at the midpoint of a pair.
  function automatic logic [NUM_W:0] pair_sum(input int k);
    pair_sum = {1'b0, OHMS[k]} + {1'b0, OHMS[k+1]};
  endfunction

  // One item as it travels down the divider chain. numq starts as the numerator
  // and fills with quotient bits from the bottom as the numerator bits leave the top.
  typedef struct packed {
    logic             valid;
    logic             fault;
    logic [ADC_W-1:0] rem;
    logic [NUM_W-1:0] numq;
    logic [ADC_W-1:0] div;
  } div_t;

endpackage

/* design/ntc_adc_to_temperature.sv */
// Top level of the NTC reading to temperature converter.
// Depends on ntc_pkg, ntc_div_cell and ntc_lookup.
//
// Usage. One raw converter reading enters on adc_code with in_valid; a transfer
// takes place at a rising edge with in_valid high and in_stall low. Every reading
// gives exactly one result on temperature_c and sample_fault, marked by out_valid
// and taken at an edge with out_stall low. Results leave in the order of arrival.
// A reading of zero or of 4096 and above gives sample_fault high and temperature 0.
// Otherwise the resistance adc*100000/(4096-adc) is formed exactly by a chain of
// 29 restoring division cells, one quotient bit per cell, and the temperature of
// the nearest table entry is chosen (the colder one on a tie).
// After an input transfer, a reading passes one input register, one multiply
// register, 29 divider cells and two lookup stages, the last being the output
// register. Throughput is one reading per cycle while the receiver keeps
// out_stall low. When the receiver stalls a waiting result, the whole pipeline
// holds; a skid register still takes one more reading, and in_stall then rises
// from a register until the pipeline moves again. Reset empties the pipeline
// and the skid register; nothing else needs clearing.
module ntc_adc_to_temperature (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [15:0]                          adc_code,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [ntc_pkg::TEMP_W-1:0]    temperature_c,
  output logic                                 sample_fault
);

  // The pipeline advances as one whenever the output register is free or being read.
  logic adv;
  assign adv = !(out_valid && out_stall);

  // Skid register: catches a reading that arrives while the pipeline holds.
  logic        skid_full;
  logic [15:0] skid_adc;
  logic        in_take;
  assign in_stall = skid_full;
  assign in_take  = in_valid && !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (in_take) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_take) begin
      skid_adc <= adc_code;
    end
  end

  // Input register: the reading is checked for a fault and trimmed to the valid width.
  logic [15:0]               sel_adc;
  logic                      front_valid;
  logic                      front_fault;
  logic [ntc_pkg::ADC_W-1:0] front_adc;
  assign sel_adc = skid_full ? skid_adc : adc_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (adv) begin
      front_valid <= skid_full || in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_fault <= (sel_adc == 16'd0) || (sel_adc >= 16'(ntc_pkg::ADC_FULL_SCALE));
      front_adc   <= sel_adc[ntc_pkg::ADC_W-1:0];
    end
  end

  // Multiply register: numerator adc*100000 and divisor full scale minus adc.
  ntc_pkg::div_t             head;
  ntc_pkg::div_t             chain [ntc_pkg::NUM_W+1];
  logic [ntc_pkg::ADC_W:0]   divisor_full;
  assign divisor_full = (ntc_pkg::ADC_W+1)'(ntc_pkg::ADC_FULL_SCALE)
                      - {1'b0, front_adc};

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (adv) begin
      head.valid <= front_valid;
      head.fault <= front_fault;
      head.rem   <= '0;
      head.numq  <= ntc_pkg::NUM_W'(front_adc) * ntc_pkg::NUM_W'(ntc_pkg::TOP_OHMS);
      head.div   <= divisor_full[ntc_pkg::ADC_W-1:0];
    end
  end

  assign chain[0] = head;

  // Divider chain: each cell settles one quotient bit, most significant first.
  for (genvar i = 0; i < ntc_pkg::NUM_W; i++) begin : g_div
    ntc_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Table lookup; its last stage drives the result ports.
  ntc_lookup u_lookup (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .din           (chain[ntc_pkg::NUM_W]),
    .out_valid     (out_valid),
    .temperature_c (temperature_c),
    .sample_fault  (sample_fault)
  );

endmodule

/* design/ntc_div_cell.sv */
// One restoring division step: brings down one numerator bit and forms one quotient bit.
// Depends on ntc_pkg for the stage record and widths.
module ntc_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  ntc_pkg::div_t din,
  output ntc_pkg::div_t dout
);

  logic [ntc_pkg::ADC_W:0]   trial;
  logic                      ge;
  logic [ntc_pkg::ADC_W:0]   diff;
  ntc_pkg::div_t             step;

  always_comb begin
    trial = {din.rem, din.numq[ntc_pkg::NUM_W-1]};
    ge    = trial >= {1'b0, din.div};
    diff  = trial - {1'b0, din.div};
    step        = din;
    step.rem    = ge ? diff[ntc_pkg::ADC_W-1:0] : trial[ntc_pkg::ADC_W-1:0];
    step.numq   = {din.numq[ntc_pkg::NUM_W-2:0], ge};
  end

  // Only the valid bit is cleared by reset; the data fields simply follow it.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= step;
    end
  end

endmodule

/* design/ntc_lookup.sv */
// Nearest-entry table lookup on the resistance, in two registered stages; the
// second stage is the block's output register. Depends on ntc_pkg.
module ntc_lookup (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  ntc_pkg::div_t                        din,
  output logic                                 out_valid,
  output logic signed [ntc_pkg::TEMP_W-1:0]    temperature_c,
  output logic                                 sample_fault
);

  // Flag k is set when the resistance lies nearer the warmer side of the midpoint of
  // pair k; the flags form a thermometer code whose count is the table index.
  logic                               s1_valid;
  logic                               s1_fault;
  logic [ntc_pkg::TABLE_ENTRIES-2:0]  s1_flags;
  logic [ntc_pkg::TABLE_ENTRIES-2:0]  flags_next;
  logic [ntc_pkg::NUM_W:0]            twice_r;
  logic [ntc_pkg::IDX_W-1:0]          idx;

  always_comb begin
    twice_r = {din.numq, 1'b0};
    for (int k = 0; k < ntc_pkg::TABLE_ENTRIES - 1; k++) begin
      flags_next[k] = twice_r < ntc_pkg::pair_sum(k);
    end
  end

  always_comb begin
    idx = '0;
    for (int k = 0; k < ntc_pkg::TABLE_ENTRIES - 1; k++) begin
      idx = idx + ntc_pkg::IDX_W'(s1_flags[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= din.valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_fault      <= din.fault;
      s1_flags      <= flags_next;
      sample_fault  <= s1_fault;
      temperature_c <= s1_fault ? '0 : ntc_pkg::CELSIUS[idx];
    end
  end

endmodule

/* bench/ntc_checker.sv */
// Result checker for the NTC reading converter: predicts each temperature from the reading.
// Watches both channels of ntc_adc_to_temperature and compares results in arrival order.
// Depends on ntc_pkg for the reading full scale and the temperature width.
module ntc_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [15:0]                       adc_code,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [ntc_pkg::TEMP_W-1:0] temperature_c,
  input  logic                              sample_fault,
  output int                                failures,
  output int                                pending_count
);

  typedef struct {
    logic [15:0]                       reading;
    logic signed [ntc_pkg::TEMP_W-1:0] celsius;
    logic                              fault;
  } temp_result_t;

  // Resistance of the thermistor at -5 C, 0 C, ... 65 C.
  localparam logic [31:0] LADDER_OHMS [15] = '{
    473000, 358200, 273400, 210200, 162900, 127200, 100000, 79210,
    63150, 50670, 40900, 33190, 27090, 22220, 18320
  };

  temp_result_t pending_temps [$];

  initial begin
    failures      = 0;
    pending_count = 0;
  end

  function automatic logic signed [ntc_pkg::TEMP_W-1:0] celsius_of_step(input int k);
    return ntc_pkg::TEMP_W'(-5 + 5 * k);
  endfunction

  function automatic temp_result_t celsius_for_reading(input logic [15:0] reading);
    temp_result_t res;
    logic [63:0]  ohms;
    logic [63:0]  warm;
    logic [63:0]  cold;
    logic         found;
    res.reading = reading;
    res.celsius = '0;
    res.fault   = 1'b0;
    found       = 1'b0;
    if (reading == 16'd0 || reading >= ntc_pkg::ADC_FULL_SCALE) begin
      res.fault = 1'b1;
      return res;
    end
    ohms = (64'(reading) * 64'd100000) / (64'(ntc_pkg::ADC_FULL_SCALE) - 64'(reading));
    if (ohms > 64'(LADDER_OHMS[0])) begin
      res.celsius = celsius_of_step(0);
    end else if (ohms < 64'(LADDER_OHMS[14])) begin
      res.celsius = celsius_of_step(14);
    end else begin
      for (int k = 1; k < 15; k++) begin
        cold = 64'(LADDER_OHMS[k-1]);
        warm = 64'(LADDER_OHMS[k]);
        if (!found && ohms <= cold && ohms >= warm) begin
          found = 1'b1;
          // A tie between the two neighbours goes to the colder entry.
          res.celsius = ((ohms - warm) < (cold - ohms)) ? celsius_of_step(k)
                                                        : celsius_of_step(k - 1);
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    temp_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_temps.size() == 0) begin
          if (failures < 10) begin
            $display("unexpected result: temperature %0d fault %0b",
                     temperature_c, sample_fault);
          end
          failures <= failures + 1;
        end else begin
          want = pending_temps.pop_front();
          if (temperature_c !== want.celsius || sample_fault !== want.fault) begin
            if (failures < 10) begin
              $display({"mismatch for reading %0d: expected temperature %0d fault %0b,",
                        " got %0d fault %0b"},
                       want.reading, want.celsius, want.fault, temperature_c, sample_fault);
            end
            failures <= failures + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        pending_temps.push_back(celsius_for_reading(adc_code));
      end
      pending_count <= pending_temps.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Top of the testbench for the NTC reading converter: clock, reset, stimulus and verdict.
// Depends on ntc_pkg, ntc_adc_to_temperature and the result checker ntc_checker.
module tb_top;

  // Resistance entries, used only to aim readings at the table and its midpoints.
  localparam longint ENTRY_OHMS [15] = '{
    473000, 358200, 273400, 210200, 162900, 127200, 100000, 79210,
    63150, 50670, 40900, 33190, 27090, 22220, 18320
  };
  localparam int RANDOM_READINGS = 1100;
  localparam int DRAIN_CYCLES    = 40;

  logic                              clk;
  logic                              rst        = 1'b1;
  logic                              in_valid   = 1'b0;
  logic                              in_stall;
  logic [15:0]                       adc_code   = 16'd0;
  logic                              out_valid;
  logic                              out_stall  = 1'b0;
  logic signed [ntc_pkg::TEMP_W-1:0] temperature_c;
  logic                              sample_fault;
  int                                failures;
  int                                pending_count;

  // Counter of the sender's burst mode, where readings follow one another with no gap.
  int burst_left = 0;

  // Counters of the receiver's stall pattern.
  int hold_left  = 0;
  int flow_left  = 0;

  ntc_adc_to_temperature DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .adc_code      (adc_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .temperature_c (temperature_c),
    .sample_fault  (sample_fault)
  );

  ntc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .adc_code      (adc_code),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .temperature_c (temperature_c),
    .sample_fault  (sample_fault),
    .failures      (failures),
    .pending_count (pending_count)
  );

  // The clock has a period of 12 units.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The reading whose resistance lies just at or below the given value, since the
  // resistance rises with the reading.
  function automatic int reading_for_ohms(input longint ohms);
    return int'((ohms * ntc_pkg::ADC_FULL_SCALE) / (ohms + 100000));
  endfunction

  function automatic int midpoint_reading(input int k);
    return reading_for_ohms((ENTRY_OHMS[k] + ENTRY_OHMS[k+1]) / 2);
  endfunction

  // Random readings: mostly valid ones, a share aimed close to the decision points
  // between two neighbouring entries, the ends of the valid range, and some faults.
  function automatic logic [15:0] random_reading();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      return 16'($urandom_range(1, ntc_pkg::ADC_FULL_SCALE - 1));
    end else if (pick < 78) begin
      return 16'(midpoint_reading($urandom_range(0, 13)) + $urandom_range(0, 6) - 3);
    end else if (pick < 84) begin
      return ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 8))
                                         : 16'($urandom_range(4087, 4095));
    end else if (pick < 91) begin
      case ($urandom_range(0, 2))
        0:       return 16'd0;
        1:       return 16'(ntc_pkg::ADC_FULL_SCALE);
        default: return 16'hFFFF;
      endcase
    end else begin
      // The full width, so that every upper bit of the field is exercised.
      return 16'($urandom());
    end
  endfunction

  // Length of the pause before the next reading. Most pauses are short, a few are
  // long, and now and then a burst of back-to-back transfers follows.
  function automatic int next_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Offers one reading and holds it, unchanged, until the transfer takes place.
  // Each call begins just after a rising edge, so only one assignment to in_valid
  // falls in any one time step.
  task automatic offer_reading(input logic [15:0] reading);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = next_gap();
      if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      adc_code <= 16'($urandom());
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_code <= reading;
    do @(posedge clk); while (in_stall);
  endtask

  // The receiver stalls at random, with short and occasional long stalls, and
  // stretches in which it takes every result as soon as it appears.
  always @(posedge clk) begin
    if (hold_left == 0) begin
      if (flow_left > 0) begin
        flow_left--;
        out_stall <= 1'b0;
        hold_left = 1;
      end else begin
        case ($urandom_range(0, 19))
          0: begin
            flow_left = $urandom_range(50, 300);
            out_stall <= 1'b0;
            hold_left = 1;
          end
          1, 2: begin
            out_stall <= 1'b1;
            hold_left = $urandom_range(10, 60);
          end
          3, 4, 5, 6, 7, 8: begin
            out_stall <= 1'b1;
            hold_left = $urandom_range(1, 3);
          end
          default: begin
            out_stall <= 1'b0;
            hold_left = $urandom_range(1, 6);
          end
        endcase
      end
    end
    hold_left--;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part: faults at both ends of the field, the ends of the valid range,
    // readings on either side of the coldest and the warmest entry (which cover the
    // clamps), and one reading beside each midpoint between two neighbours.
    offer_reading(16'd0);
    offer_reading(16'd1);
    offer_reading(16'(ntc_pkg::ADC_FULL_SCALE - 1));
    offer_reading(16'(ntc_pkg::ADC_FULL_SCALE));
    offer_reading(16'h8000);
    offer_reading(16'hFFFF);
    offer_reading(16'(reading_for_ohms(ENTRY_OHMS[0])));
    offer_reading(16'(reading_for_ohms(ENTRY_OHMS[0]) + 1));
    offer_reading(16'(reading_for_ohms(ENTRY_OHMS[14])));
    offer_reading(16'(reading_for_ohms(ENTRY_OHMS[14]) + 1));
    for (int k = 0; k < 14; k++) begin
      offer_reading(16'(midpoint_reading(k)));
    end

    for (int n = 0; n < RANDOM_READINGS; n++) begin
      offer_reading(random_reading());
    end
    in_valid <= 1'b0;

    // One more edge lets the checker record the last transfer before the drain.
    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin : watchdog
    #(12 * 600000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
